// File: rtl/psu_pkg.sv
`timescale 1ns / 1ps
// psu_pkg: shared constants, filter codes and the work item type for the png unfilter
// used by psu_front, psu_queue, psu_back, png_scanline_unfilter_core and psu_checker; no dependencies

package psu_pkg;

	// geometry limits
	localparam int MAX_ROW_BYTES   = 8192;
	localparam int MAX_PIXEL_BYTES = 8;
	localparam int ADDR_W          = $clog2(MAX_ROW_BYTES);
	localparam int CNT_W           = ADDR_W + 1;
	localparam int HIST_W          = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	// register widths
	localparam int ROW_BYTES_W = 14;
	localparam int BPP_W       = 4;
	localparam int CFG_DATA_W  = 14;
	localparam int CFG_IDX_W   = 1;
	localparam int CMP_W       = (CNT_W > ROW_BYTES_W) ? CNT_W : ROW_BYTES_W;

	// register reset values
	localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = ROW_BYTES_W'(4);
	localparam logic [BPP_W-1:0]       BPP_RST       = BPP_W'(4);

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// stream payload widths
	localparam int BYTE_W = 8;

	// filter types, unsupported types collapse to one code
	typedef enum logic [2:0] {
		FILT_NONE = 3'd0,
		FILT_SUB  = 3'd1,
		FILT_UP   = 3'd2,
		FILT_AVG  = 3'd3,
		FILT_BAD  = 3'd5
	} filter_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_BYTES = 1'd0,
		CFG_BPP       = 1'd1
	} cfg_idx_t;

	// one classified sample handed from front to back
	typedef struct packed {
		logic [ADDR_W-1:0] col;
		logic              first_row;
		filter_t           filt;
		logic              left_ok;
		logic [HIST_W-1:0] bpp_m1;
		logic              last;
		logic [BYTE_W-1:0] data;
	} work_t;

endpackage

// File: rtl/psu_front.sv
`timescale 1ns / 1ps
// psu_front: configuration registers, row tracking and classification of input bytes
// depends on psu_pkg

module psu_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [psu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [psu_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_fire,
	input  logic [psu_pkg::BYTE_W-1:0]        in_byte,
	input  logic                              in_soi,
	output logic                              push,
	output psu_pkg::work_t                    push_item
);

	logic [psu_pkg::ROW_BYTES_W-1:0] row_bytes_q;
	logic [psu_pkg::BPP_W-1:0]       bpp_q;
	logic [psu_pkg::ADDR_W-1:0]      col_q;
	logic                            awaiting_q;
	logic                            first_row_q;
	psu_pkg::filter_t                filt_q;

	logic [psu_pkg::CMP_W-1:0]       row_ext;
	logic [psu_pkg::CNT_W-1:0]       len_eff;
	logic [psu_pkg::BPP_W-1:0]       bpp_eff;
	logic                            is_filter;
	logic                            last;
	psu_pkg::filter_t                new_filt;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= psu_pkg::ROW_BYTES_RST;
			bpp_q       <= psu_pkg::BPP_RST;
		end else if (cfg_we) begin
			case (psu_pkg::cfg_idx_t'(cfg_index))
				psu_pkg::CFG_ROW_BYTES: row_bytes_q <= psu_pkg::ROW_BYTES_W'(cfg_data);
				psu_pkg::CFG_BPP:       bpp_q       <= psu_pkg::BPP_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// clamp row length and pixel size into their legal ranges
	always_comb begin
		row_ext = psu_pkg::CMP_W'(row_bytes_q);
		if (row_ext == '0) begin
			len_eff = psu_pkg::CNT_W'(1);
		end else if (row_ext > psu_pkg::CMP_W'(psu_pkg::MAX_ROW_BYTES)) begin
			len_eff = psu_pkg::CNT_W'(psu_pkg::MAX_ROW_BYTES);
		end else begin
			len_eff = psu_pkg::CNT_W'(row_ext);
		end
		if (bpp_q == '0) begin
			bpp_eff = psu_pkg::BPP_W'(1);
		end else if (bpp_q > psu_pkg::BPP_W'(psu_pkg::MAX_PIXEL_BYTES)) begin
			bpp_eff = psu_pkg::BPP_W'(psu_pkg::MAX_PIXEL_BYTES);
		end else begin
			bpp_eff = bpp_q;
		end
	end

	// classify the byte
	always_comb begin
		is_filter = in_soi | awaiting_q;
		last      = (psu_pkg::CNT_W'(col_q) + psu_pkg::CNT_W'(1)) >= len_eff;
		if (in_byte > psu_pkg::BYTE_W'(3)) begin
			new_filt = psu_pkg::FILT_BAD;
		end else begin
			new_filt = psu_pkg::filter_t'(in_byte[2:0]);
		end
	end

	// work item for the back end
	always_comb begin
		push                = in_fire & ~is_filter;
		push_item.col       = col_q;
		push_item.first_row = first_row_q;
		push_item.filt      = filt_q;
		push_item.left_ok   = psu_pkg::CNT_W'(col_q) >= psu_pkg::CNT_W'(bpp_eff);
		push_item.bpp_m1    = psu_pkg::HIST_W'(bpp_eff - psu_pkg::BPP_W'(1));
		push_item.last      = last;
		push_item.data      = in_byte;
	end

	// row position and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			awaiting_q  <= 1'b1;
			first_row_q <= 1'b1;
			filt_q      <= psu_pkg::FILT_NONE;
		end else if (in_fire) begin
			if (is_filter) begin
				filt_q     <= new_filt;
				col_q      <= '0;
				awaiting_q <= 1'b0;
				if (in_soi) begin
					first_row_q <= 1'b1;
				end
			end else if (last) begin
				col_q       <= '0;
				awaiting_q  <= 1'b1;
				first_row_q <= 1'b0;
			end else begin
				col_q <= col_q + psu_pkg::ADDR_W'(1);
			end
		end
	end

endmodule

// File: rtl/psu_queue.sv
`timescale 1ns / 1ps
// psu_queue: short fifo of work items between the front and the back end
// depends on psu_pkg

module psu_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  psu_pkg::work_t push_item,
	input  logic           pop,
	output logic           full,
	output logic           valid,
	output psu_pkg::work_t head
);

	psu_pkg::work_t                entry_q [psu_pkg::QDEPTH];
	logic [psu_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [psu_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [psu_pkg::QPTR_W:0]      count_q;

	assign full  = count_q == (psu_pkg::QPTR_W + 1)'(psu_pkg::QDEPTH);
	assign valid = count_q != '0;
	assign head  = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + psu_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + psu_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (psu_pkg::QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (psu_pkg::QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/psu_back.sv
`timescale 1ns / 1ps
// psu_back: prior-row line buffer, left history and reconstruction with output register
// depends on psu_pkg

module psu_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  psu_pkg::work_t             q_head,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [psu_pkg::BYTE_W-1:0] out_pixel,
	output logic                       out_last,
	output logic                       out_status
);

	logic [psu_pkg::BYTE_W-1:0] prior_mem [psu_pkg::MAX_ROW_BYTES];
	logic [psu_pkg::BYTE_W-1:0] hist_q    [psu_pkg::MAX_PIXEL_BYTES];

	logic                       v_s1;
	psu_pkg::work_t             item_s1;
	logic [psu_pkg::BYTE_W-1:0] rd_s1;
	logic                       fwd_s1;
	logic [psu_pkg::BYTE_W-1:0] fwd_data_s1;

	logic                       v_s2;
	logic [psu_pkg::BYTE_W-1:0] pixel_s2;
	logic                       last_s2;
	logic                       status_s2;

	logic                       adv_out;
	logic                       load_s1;
	logic                       fire_s1;
	logic [psu_pkg::BYTE_W-1:0] above;
	logic [psu_pkg::BYTE_W-1:0] left;
	logic [psu_pkg::BYTE_W:0]   pair_sum;
	logic [psu_pkg::BYTE_W-1:0] result;
	logic                       status;

	// stage flow
	assign adv_out = ~v_s2 | out_ready;
	assign load_s1 = ~v_s1 | adv_out;
	assign fire_s1 = v_s1 & adv_out;
	assign q_pop   = q_valid & load_s1;

	// neighbours and reconstruction
	always_comb begin
		if (item_s1.first_row) begin
			above = '0;
		end else if (fwd_s1) begin
			above = fwd_data_s1;
		end else begin
			above = rd_s1;
		end
		left     = item_s1.left_ok ? hist_q[item_s1.bpp_m1] : '0;
		pair_sum = {1'b0, left} + {1'b0, above};
		status   = 1'b0;
		case (item_s1.filt)
			psu_pkg::FILT_NONE: result = item_s1.data;
			psu_pkg::FILT_SUB:  result = item_s1.data + left;
			psu_pkg::FILT_UP:   result = item_s1.data + above;
			psu_pkg::FILT_AVG:  result = item_s1.data + pair_sum[psu_pkg::BYTE_W:1];
			default: begin
				result = '0;
				status = 1'b1;
			end
		endcase
	end

	// line buffer write as each sample completes
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			prior_mem[item_s1.col] <= result;
		end
	end

	// line buffer read when an item enters stage 1
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_s1 <= prior_mem[q_head.col];
		end
	end

	// stage 1 payload, with bypass when the item ahead writes the same column
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1     <= q_head;
			fwd_s1      <= fire_s1 & (item_s1.col == q_head.col);
			fwd_data_s1 <= result;
		end
	end

	// left history, newest first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < psu_pkg::MAX_PIXEL_BYTES; i++) begin
				hist_q[i] <= '0;
			end
		end else if (fire_s1) begin
			hist_q[0] <= result;
			for (int i = 1; i < psu_pkg::MAX_PIXEL_BYTES; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			pixel_s2  <= result;
			last_s2   <= item_s1.last;
			status_s2 <= status;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1 <= q_valid;
			end
			if (adv_out) begin
				v_s2 <= v_s1;
			end
		end
	end

	assign out_valid  = v_s2;
	assign out_pixel  = pixel_s2;
	assign out_last   = last_s2;
	assign out_status = status_s2;

endmodule

// File: rtl/png_scanline_unfilter_core.sv
`timescale 1ns / 1ps
// png_scanline_unfilter_core: top level of the png scanline unfilter
// depends on psu_pkg, psu_front, psu_queue, psu_back
//
//  channel   direction  payload
//  s_axis    in         tdata = data_byte[7:0], tuser = start_of_image
//  m_axis    out        tdata = pixel_byte[7:0], tlast = end_of_row, tuser = status
//  cfg       in         index 0 row_bytes[13:0], index 1 bytes_per_pixel[3:0]
//
// one byte is taken every cycle while the queue is not full; filter type bytes give no result
// a sample passes to m_axis through the queue write, the line buffer read,
// then reconstruction into the output register
// a stalled m_axis fills the four-entry queue before s_axis tready drops
// reset clears row tracking and the queue; the line buffer needs no clearing pass

module png_scanline_unfilter_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [psu_pkg::BYTE_W-1:0]         s_axis_tdata,   // data_byte[7:0]
	input  logic                               s_axis_tuser,   // start_of_image
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [psu_pkg::BYTE_W-1:0]         m_axis_tdata,   // pixel_byte[7:0]
	output logic                               m_axis_tlast,
	output logic                               m_axis_tuser,   // status
	input  logic                               cfg_we,
	input  logic [psu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [psu_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic           in_fire;
	logic           push;
	psu_pkg::work_t push_item;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;
	psu_pkg::work_t q_head;

	assign s_axis_tready = ~q_full;
	assign in_fire       = s_axis_tvalid & ~q_full;

	// byte classification and row tracking
	psu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_fire   (in_fire),
		.in_byte   (s_axis_tdata),
		.in_soi    (s_axis_tuser),
		.push      (push),
		.push_item (push_item)
	);

	// decoupling queue
	psu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (q_pop),
		.full      (q_full),
		.valid     (q_valid),
		.head      (q_head)
	);

	// reconstruction
	psu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_pixel  (m_axis_tdata),
		.out_last   (m_axis_tlast),
		.out_status (m_axis_tuser)
	);

endmodule

// File: rtl/psu_checker.sv
`timescale 1ns / 1ps
// psu_checker: port-level assertions for png_scanline_unfilter_core, bound to the top level
// depends on psu_pkg

module psu_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tready,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [psu_pkg::BYTE_W-1:0] m_axis_tdata,
	input logic                       m_axis_tlast,
	input logic                       m_axis_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// an unsupported filter always yields a zero byte
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("error status with nonzero pixel");

	// input back pressure only comes from a stalled output
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

endmodule

bind png_scanline_unfilter_core psu_checker u_psu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
